[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks expr at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/ttfr_pkg.sv]
`timescale 1ns / 1ps

package ttfr_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h43;
   localparam logic [7:0] HDR_SECOND = 8'h47;
   localparam logic [7:0] TAG_ALERT  = 8'h16;
   localparam logic [7:0] TAG_CLEAR  = 8'h15;
   localparam logic [7:0] MARK_BYTE  = 8'h0F;
   localparam logic [7:0] TAIL_A     = 8'h4E;
   localparam logic [7:0] TAIL_B     = 8'h4F;

   localparam int TAG_POS   = 4;
   localparam int MARK_POS  = 17;
   localparam int CHECK_LEN = 21;
   localparam int HDR_LEN   = 2;

   typedef enum logic [1:0] {
      EV_ALERT   = 2'd0,
      EV_CLEAR   = 2'd1,
      EV_PAYLOAD = 2'd2,
      EV_REJECT  = 2'd3
   } event_type;

endpackage

[hw/rtl/ttfr_ram.sv]
`timescale 1ns / 1ps

module ttfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 25
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/two_type_frame_receiver.sv]
`timescale 1ns / 1ps

// Frame receiver for header 0x43 0x47 links carrying collision and sensor
// frames. Each byte beat that does not end a frame is accepted unless the held
// output is stalled; the frame bytes go into a LONG_FRAME_BYTES-deep RAM with a
// registered read. A collision frame ends at byte 21 with one result beat. A
// sensor frame (csr link mode 0) ends at byte LONG_FRAME_BYTES and is read back
// from the RAM as LONG_FRAME_BYTES-2 payload beats, one per cycle behind the
// read latency unless the output stalls; the input is stalled during that
// drain. A line error drops the frame and restarts the header hunt; the
// collision flag is kept. Write csr_wr_data only while the block is idle.
module two_type_frame_receiver #(
   parameter int LONG_FRAME_BYTES = 25
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_line_error,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_event_res,
   output logic [7:0] rsp_payload_byte,
   output logic [4:0] rsp_payload_index,
   output logic       rsp_last,
   output logic       rsp_collision_active
);

   `include "assert_macros.svh"

   localparam int AW = $clog2(LONG_FRAME_BYTES);
   localparam int CW = $clog2(LONG_FRAME_BYTES + 1);

   localparam logic [CW-1:0] CNT_HDR   = CW'(ttfr_pkg::HDR_LEN);
   localparam logic [CW-1:0] CNT_TAG   = CW'(ttfr_pkg::TAG_POS);
   localparam logic [CW-1:0] CNT_MARK  = CW'(ttfr_pkg::MARK_POS);
   localparam logic [CW-1:0] CNT_CHECK = CW'(ttfr_pkg::CHECK_LEN - 1);
   localparam logic [CW-1:0] CNT_END   = CW'(LONG_FRAME_BYTES - 1);
   localparam logic [AW-1:0] ADDR_FIRST = AW'(ttfr_pkg::HDR_LEN);
   localparam logic [AW-1:0] ADDR_LAST  = AW'(LONG_FRAME_BYTES - 1);

   typedef enum logic [3:0] {
      ST_HUNT_FIRST  = 4'b0001,
      ST_HUNT_SECOND = 4'b0010,
      ST_BODY        = 4'b0100,
      ST_DRAIN       = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            mode_ff, mode_in;
   logic            collision_ff, collision_in;
   logic            tag_ok_ff, tag_ok_in;
   logic            tag_alert_ff, tag_alert_in;
   logic            mark_ok_ff, mark_ok_in;

   logic [AW-1:0]   rd_addr_ff, rd_addr_in;
   logic            issue_done_ff, issue_done_in;
   logic [AW-1:0]   rd_idx_ff, rd_idx_in;
   logic            rd_valid_ff, rd_valid_in;

   logic            rsp_valid_ff, rsp_valid_in;
   ttfr_pkg::event_type rsp_event_ff, rsp_event_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic [4:0]      rsp_index_ff, rsp_index_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_coll_ff, rsp_coll_in;

   logic            accept;
   logic            wr_en;
   logic            issue;
   logic            out_load;
   logic            rd_last;
   logic            item_emit;
   ttfr_pkg::event_type item_event;
   logic            tail_ok;
   logic            sig_ok;
   logic [7:0]      rd_data;

   assign req_stall = (state_ff == ST_DRAIN) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign tail_ok = (req_rx_byte == ttfr_pkg::TAIL_A) || (req_rx_byte == ttfr_pkg::TAIL_B);
   assign sig_ok  = tag_ok_ff && mark_ok_ff && tail_ok;

   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      collision_in = collision_ff;
      tag_ok_in    = tag_ok_ff;
      tag_alert_in = tag_alert_ff;
      mark_ok_in   = mark_ok_ff;
      rd_addr_in   = rd_addr_ff;
      issue_done_in = issue_done_ff;
      wr_en        = 1'b0;
      item_emit    = 1'b0;
      item_event   = ttfr_pkg::EV_REJECT;
      if (accept) begin
         if (req_line_error) begin
            state_in = ST_HUNT_FIRST;
            count_in = '0;
         end else begin
            unique case (state_ff)
               ST_HUNT_SECOND: begin
                  if (req_rx_byte == ttfr_pkg::HDR_SECOND) begin
                     state_in = ST_BODY;
                     count_in = CNT_HDR;
                  end else if (req_rx_byte != ttfr_pkg::HDR_FIRST) begin
                     state_in = ST_HUNT_FIRST;
                  end
               end
               ST_BODY: begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
                  if (count_ff == CNT_TAG) begin
                     tag_alert_in = req_rx_byte == ttfr_pkg::TAG_ALERT;
                     tag_ok_in    = (req_rx_byte == ttfr_pkg::TAG_ALERT) ||
                                    (req_rx_byte == ttfr_pkg::TAG_CLEAR);
                  end
                  if (count_ff == CNT_MARK) begin
                     mark_ok_in = req_rx_byte == ttfr_pkg::MARK_BYTE;
                  end
                  if (count_ff == CNT_CHECK) begin
                     if (sig_ok) begin
                        collision_in = tag_alert_ff;
                        item_emit    = 1'b1;
                        item_event   = tag_alert_ff ? ttfr_pkg::EV_ALERT
                                                    : ttfr_pkg::EV_CLEAR;
                        state_in     = ST_HUNT_FIRST;
                        count_in     = '0;
                     end else if (mode_ff) begin
                        item_emit = 1'b1;
                        state_in  = ST_HUNT_FIRST;
                        count_in  = '0;
                     end
                  end else if (count_ff == CNT_END) begin
                     count_in = '0;
                     if (mode_ff) begin
                        item_emit = 1'b1;
                        state_in  = ST_HUNT_FIRST;
                     end else begin
                        state_in      = ST_DRAIN;
                        rd_addr_in    = ADDR_FIRST;
                        issue_done_in = 1'b0;
                     end
                  end
               end
               ST_DRAIN: begin
               end
               default: begin
                  if (req_rx_byte == ttfr_pkg::HDR_FIRST) begin
                     state_in = ST_HUNT_SECOND;
                  end else begin
                     state_in = ST_HUNT_FIRST;
                  end
                  count_in = '0;
               end
            endcase
         end
      end
      if (issue) begin
         rd_addr_in    = rd_addr_ff + AW'(1);
         issue_done_in = rd_addr_ff == ADDR_LAST;
      end
      if (out_load && rd_last) begin
         state_in = ST_HUNT_FIRST;
      end
   end

   // drain pipeline: RAM read, then output register
   assign rd_last  = rd_idx_ff == ADDR_LAST;
   assign out_load = rd_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue    = (state_ff == ST_DRAIN) && !issue_done_ff &&
                     (!rd_valid_ff || out_load);
   assign rd_idx_in   = issue ? rd_addr_ff : rd_idx_ff;
   assign rd_valid_in = issue || (rd_valid_ff && !out_load);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_event_in = rsp_event_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_coll_in  = rsp_coll_ff;
      if (item_emit) begin
         rsp_valid_in = 1'b1;
         rsp_event_in = item_event;
         rsp_byte_in  = '0;
         rsp_index_in = '0;
         rsp_last_in  = 1'b1;
         rsp_coll_in  = collision_in;
      end else if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_event_in = ttfr_pkg::EV_PAYLOAD;
         rsp_byte_in  = rd_data;
         rsp_index_in = 5'(rd_idx_ff - ADDR_FIRST);
         rsp_last_in  = rd_last;
         rsp_coll_in  = collision_ff;
      end
   end

   ttfr_ram #(
      .WIDTH (8),
      .DEPTH (LONG_FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (issue),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_HUNT_FIRST;
         count_ff      <= '0;
         mode_ff       <= 1'b0;
         collision_ff  <= 1'b0;
         issue_done_ff <= 1'b1;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         mode_ff       <= mode_in;
         collision_ff  <= collision_in;
         issue_done_ff <= issue_done_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ok_ff    <= tag_ok_in;
      tag_alert_ff <= tag_alert_in;
      mark_ok_ff   <= mark_ok_in;
      rd_addr_ff   <= rd_addr_in;
      rd_idx_ff    <= rd_idx_in;
      rsp_event_ff <= rsp_event_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_coll_ff  <= rsp_coll_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_event_res        = rsp_event_ff;
   assign rsp_payload_byte     = rsp_byte_ff;
   assign rsp_payload_index    = rsp_index_ff;
   assign rsp_last             = rsp_last_ff;
   assign rsp_collision_active = rsp_coll_ff;

   `ASSERT_IMPL(a_rd_only_in_drain, rd_valid_ff, state_ff == ST_DRAIN, "read beat outside drain")
   `ASSERT_IMPL(a_payload_index_range,
      rsp_valid_ff && rsp_event_ff == ttfr_pkg::EV_PAYLOAD,
      rsp_index_ff <= 5'(LONG_FRAME_BYTES - 3), "payload index past frame")
   `ASSERT_IMPL(a_event_single_beat,
      rsp_valid_ff && rsp_event_ff != ttfr_pkg::EV_PAYLOAD,
      rsp_last_ff && rsp_byte_ff == 8'h00 && rsp_index_ff == 5'd0, "bad single-beat event")
   `ASSERT_NEXT(a_drain_exit, out_load && rd_last,
      state_ff == ST_HUNT_FIRST && !rd_valid_ff, "drain did not finish")

endmodule
